[src/assert_macros.svh]
// assertion macros shared by the pooling rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define P2D_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define P2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/p2d_pkg.sv]
// shared types, constants and helpers of the 2-d pooling block
`timescale 1ns / 1ps

package p2d_pkg;

    localparam int MAX_IMAGE_WIDTH = 1024;
    localparam int MAX_IMAGE_HEIGHT = 1024;
    localparam int MAX_POOL = 8;
    localparam int SAMPLE_BITS = 16;

    localparam int POOL_BITS = 4;
    localparam int IMG_BITS = 11;
    localparam int POS_BITS = 10;
    localparam int OFF_BITS = 3;
    localparam int SUM_BITS = 22;
    localparam int DIV_BITS = 7;
    localparam int DIV_STEPS = SUM_BITS;
    localparam int DIV_CNT_BITS = 5;
    localparam int ADDR_BITS = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_POOL_WIDTH = 3'd1;
    localparam logic [2:0] REG_POOL_HEIGHT = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_DIV,
        ST_OUT
    } state_t;

    // one column entry of the partial store
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] best;
        logic [OFF_BITS-1:0]           off_x;
        logic [OFF_BITS-1:0]           off_y;
        logic signed [SUM_BITS-1:0]    sum;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [POOL_BITS-1:0] clamp_pool(input logic [POOL_BITS-1:0] v);
        logic [POOL_BITS-1:0] r;
        if (v == '0) begin
            r = POOL_BITS'(1);
        end else if (v > POOL_BITS'(MAX_POOL)) begin
            r = POOL_BITS'(MAX_POOL);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [IMG_BITS-1:0] clamp_img(input logic [IMG_BITS-1:0] v,
                                                     input logic [IMG_BITS-1:0] hi);
        logic [IMG_BITS-1:0] r;
        if (v == '0) begin
            r = IMG_BITS'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[src/p2d_ram.sv]
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module p2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/p2d_div.sv]
// bit-serial signed divider for the window average, truncates toward zero
`timescale 1ns / 1ps

module p2d_div
    import p2d_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [SUM_BITS-1:0]    dividend,
    input  logic [DIV_BITS-1:0]           divisor,
    output logic signed [SAMPLE_BITS-1:0] quotient,
    output div_stat_t                     stat
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]     num_reg, num_next;
    logic [DIV_BITS-1:0]     rem_reg, rem_next;
    logic [DIV_BITS-1:0]     den_reg, den_next;
    logic                    neg_reg, neg_next;
    logic [DIV_BITS:0]       trial;
    logic [SUM_BITS-1:0]     q_signed;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, num_reg[SUM_BITS-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIV_STEPS - 1);
            neg_next  = dividend[SUM_BITS-1];
            num_next  = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            // restoring step: one quotient bit per cycle
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DIV_BITS'(trial - {1'b0, den_reg});
                num_next = {num_reg[SUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_BITS-1:0];
                num_next = {num_reg[SUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign q_signed  = neg_reg ? (~num_reg + SUM_BITS'(1)) : num_reg;
    assign quotient  = q_signed[SAMPLE_BITS-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[src/pooling_2d_max_avg_top.sv]
// top level of the streaming 2-d max / average pooling block
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Streaming 2-d pooling over non-overlapping windows of up to 8x8 samples, planes
// up to 1024 samples wide. A sample that falls outside every whole window is only
// counted. A sample inside a window passes through accept and read of its column
// entry in the partial store, then modify and write-back. The last sample of a
// window then loads the output register in max mode; in average mode a bit-serial
// divider first produces one quotient bit per cycle (22 steps), and the quotient
// is taken into the result staging register before the output register load.
// That load waits while the previous result is still not taken.
// One item is in work at a time; the output register lets the next sample be
// accepted while a result waits to be taken. The partial store is one 1024 x 44
// memory, written on the first sample of each window before it is read, so it
// needs no clearing after reset. Any register write restarts the plane.
module pooling_2d_max_avg_top
    import p2d_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // samples in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    // results out
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_pooled_value,
    output logic [OFF_BITS-1:0]           m_max_offset_x,
    output logic [OFF_BITS-1:0]           m_max_offset_y,
    output logic [POS_BITS-1:0]           m_out_column,
    output logic [POS_BITS-1:0]           m_out_row,
    output logic                          m_plane_done
);

    localparam int RAM_DEPTH = MAX_IMAGE_WIDTH;
    localparam int PROD_BITS = IMG_BITS + POOL_BITS;

    // configuration registers
    logic                 mode_reg;
    logic [POOL_BITS-1:0] pw_reg, ph_reg;
    logic [IMG_BITS-1:0]  iw_reg, ih_reg;
    logic [POOL_BITS-1:0] pw_c, ph_c;
    logic [IMG_BITS-1:0]  iw_c, ih_c;
    logic                 cfg_wr;
    logic [2:0]           cfg_idx;
    logic                 cfg_hit;

    // position counters
    logic [POS_BITS-1:0] col_cnt_reg, col_cnt_next;
    logic [POS_BITS-1:0] row_cnt_reg, row_cnt_next;
    logic [OFF_BITS-1:0] ciw_reg, ciw_next;
    logic [OFF_BITS-1:0] riw_reg, riw_next;
    logic [POS_BITS-1:0] wcol_reg, wcol_next;
    logic [POS_BITS-1:0] wrow_reg, wrow_next;

    // captured item
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic                          first_reg;
    logic                          last_reg;
    logic                          pdone_reg;
    logic [OFF_BITS-1:0]           ciw_cap_reg, riw_cap_reg;
    logic [POS_BITS-1:0]           wcol_cap_reg, wrow_cap_reg;

    // result staging
    logic signed [SAMPLE_BITS-1:0] res_value_reg;
    logic [OFF_BITS-1:0]           res_offx_reg, res_offy_reg;

    // output register
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_value_reg;
    logic [OFF_BITS-1:0]           m_offx_reg, m_offy_reg;
    logic [POS_BITS-1:0]           m_col_reg, m_row_reg;
    logic                          m_pdone_reg;

    state_t state_reg, state_next;

    logic                     accept;
    logic [PROD_BITS-1:0]     col_end, row_end;
    logic                     in_win, col_last, row_last;
    logic [IMG_BITS-1:0]      col_inc, row_inc;
    logic [POOL_BITS-1:0]     ciw_inc, riw_inc;
    logic                     ram_we;
    logic [ENTRY_BITS-1:0]    ram_rdata;
    entry_t                   rd_entry, wr_entry;
    logic signed [SUM_BITS-1:0] samp_ext;
    logic                     take_new;
    logic                     div_start;
    logic [DIV_BITS-1:0]      div_den;
    logic signed [SAMPLE_BITS-1:0] div_q;
    div_stat_t                div_stat;
    logic                     out_load;

    assign pw_c = clamp_pool(pw_reg);
    assign ph_c = clamp_pool(ph_reg);
    assign iw_c = clamp_img(iw_reg, IMG_BITS'(MAX_IMAGE_WIDTH));
    assign ih_c = clamp_img(ih_reg, IMG_BITS'(MAX_IMAGE_HEIGHT));

    // apb port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign cfg_hit = cfg_wr && (cfg_idx == REG_MODE || cfg_idx == REG_POOL_WIDTH ||
                                cfg_idx == REG_POOL_HEIGHT || cfg_idx == REG_IMAGE_WIDTH ||
                                cfg_idx == REG_IMAGE_HEIGHT);

    always_comb begin
        case (cfg_idx)
            REG_MODE:         prdata = {31'd0, mode_reg};
            REG_POOL_WIDTH:   prdata = {28'd0, pw_reg};
            REG_POOL_HEIGHT:  prdata = {28'd0, ph_reg};
            REG_IMAGE_WIDTH:  prdata = {21'd0, iw_reg};
            REG_IMAGE_HEIGHT: prdata = {21'd0, ih_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_MAX;
            pw_reg   <= POOL_BITS'(2);
            ph_reg   <= POOL_BITS'(2);
            iw_reg   <= IMG_BITS'(1024);
            ih_reg   <= IMG_BITS'(1024);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE:         mode_reg <= pwdata[0];
                REG_POOL_WIDTH:   pw_reg   <= pwdata[POOL_BITS-1:0];
                REG_POOL_HEIGHT:  ph_reg   <= pwdata[POOL_BITS-1:0];
                REG_IMAGE_WIDTH:  iw_reg   <= pwdata[IMG_BITS-1:0];
                REG_IMAGE_HEIGHT: ih_reg   <= pwdata[IMG_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // window fit: (index + 1) * pool <= image, last window when one more would not fit
    assign col_end  = PROD_BITS'({1'b0, wcol_reg} + IMG_BITS'(1)) * PROD_BITS'(pw_c);
    assign row_end  = PROD_BITS'({1'b0, wrow_reg} + IMG_BITS'(1)) * PROD_BITS'(ph_c);
    assign in_win   = (col_end <= PROD_BITS'(iw_c)) && (row_end <= PROD_BITS'(ih_c));
    assign col_last = (col_end + PROD_BITS'(pw_c)) > PROD_BITS'(iw_c);
    assign row_last = (row_end + PROD_BITS'(ph_c)) > PROD_BITS'(ih_c);

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // raster counters advance on every accepted sample, unless a register write restarts the plane
    always_comb begin
        col_inc      = {1'b0, col_cnt_reg} + IMG_BITS'(1);
        ciw_inc      = {1'b0, ciw_reg} + POOL_BITS'(1);
        row_inc      = {1'b0, row_cnt_reg} + IMG_BITS'(1);
        riw_inc      = {1'b0, riw_reg} + POOL_BITS'(1);
        col_cnt_next = col_inc[POS_BITS-1:0];
        ciw_next     = ciw_inc[OFF_BITS-1:0];
        wcol_next    = wcol_reg;
        row_cnt_next = row_cnt_reg;
        riw_next     = riw_reg;
        wrow_next    = wrow_reg;
        if (ciw_inc >= pw_c) begin
            ciw_next  = '0;
            wcol_next = wcol_reg + POS_BITS'(1);
        end
        if (col_inc >= iw_c) begin
            col_cnt_next = '0;
            ciw_next     = '0;
            wcol_next    = '0;
            row_cnt_next = row_inc[POS_BITS-1:0];
            riw_next     = riw_inc[OFF_BITS-1:0];
            if (riw_inc >= ph_c) begin
                riw_next  = '0;
                wrow_next = wrow_reg + POS_BITS'(1);
            end
            if (row_inc >= ih_c) begin
                row_cnt_next = '0;
                riw_next     = '0;
                wrow_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            ciw_reg     <= '0;
            riw_reg     <= '0;
            wcol_reg    <= '0;
            wrow_reg    <= '0;
        end else if (cfg_hit) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            ciw_reg     <= '0;
            riw_reg     <= '0;
            wcol_reg    <= '0;
            wrow_reg    <= '0;
        end else if (accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            ciw_reg     <= ciw_next;
            riw_reg     <= riw_next;
            wcol_reg    <= wcol_next;
            wrow_reg    <= wrow_next;
        end
    end

    // capture the sample and where it sits
    always_ff @(posedge aclk) begin
        if (accept) begin
            samp_reg     <= s_sample;
            first_reg    <= (ciw_reg == '0) && (riw_reg == '0);
            last_reg     <= (ciw_inc == pw_c) && (riw_inc == ph_c);
            pdone_reg    <= col_last && row_last;
            ciw_cap_reg  <= ciw_reg;
            riw_cap_reg  <= riw_reg;
            wcol_cap_reg <= wcol_reg;
            wrow_cap_reg <= wrow_reg;
        end
    end

    // read-modify-write of the column entry; the fsm keeps one access in flight
    p2d_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wcol_cap_reg),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (wcol_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign samp_ext = {{(SUM_BITS-SAMPLE_BITS){samp_reg[SAMPLE_BITS-1]}}, samp_reg};

    // ties on value go to the smaller column seen so far
    assign take_new = (samp_reg > rd_entry.best) ||
                      ((samp_reg == rd_entry.best) && (ciw_cap_reg < rd_entry.off_x));

    always_comb begin
        if (first_reg) begin
            wr_entry.best  = samp_reg;
            wr_entry.off_x = '0;
            wr_entry.off_y = '0;
            wr_entry.sum   = samp_ext;
        end else begin
            wr_entry.sum = rd_entry.sum + samp_ext;
            if (take_new) begin
                wr_entry.best  = samp_reg;
                wr_entry.off_x = ciw_cap_reg;
                wr_entry.off_y = riw_cap_reg;
            end else begin
                wr_entry.best  = rd_entry.best;
                wr_entry.off_x = rd_entry.off_x;
                wr_entry.off_y = rd_entry.off_y;
            end
        end
    end

    assign div_den = DIV_BITS'(pw_c) * DIV_BITS'(ph_c);

    p2d_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (wr_entry.sum),
        .divisor  (div_den),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // control
    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_win) begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                ram_we = 1'b1;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (mode_reg == MODE_AVG) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MODIFY) begin
            res_value_reg <= wr_entry.best;
            res_offx_reg  <= wr_entry.off_x;
            res_offy_reg  <= wr_entry.off_y;
        end else if (state_reg == ST_DIV && div_stat.done) begin
            res_value_reg <= div_q;
            res_offx_reg  <= '0;
            res_offy_reg  <= '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg <= res_value_reg;
            m_offx_reg  <= res_offx_reg;
            m_offy_reg  <= res_offy_reg;
            m_col_reg   <= wcol_cap_reg;
            m_row_reg   <= wrow_cap_reg;
            m_pdone_reg <= pdone_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pooled_value = m_value_reg;
    assign m_max_offset_x = m_offx_reg;
    assign m_max_offset_y = m_offy_reg;
    assign m_out_column   = m_col_reg;
    assign m_out_row      = m_row_reg;
    assign m_plane_done   = m_pdone_reg;

    `P2D_ASSERT_NEXT(a_win_goes_modify, accept && in_win, state_reg == ST_MODIFY,
        "in-window sample did not reach the modify step")
    `P2D_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_reg == ST_DIV,
        "divider finished outside the divide state")
    `P2D_ASSERT_IMP(a_div_start_free, div_start, !div_stat.busy,
        "divider started while busy")
    `P2D_ASSERT_NEXT(a_cfg_restart, cfg_hit,
        col_cnt_reg == '0 && wcol_reg == '0 && wrow_reg == '0,
        "register write did not restart the plane")

endmodule
